>>> rtl/jrle_pkg.sv
// Shared types and constants for the run-length expander.
package jrle_pkg;

	localparam int BLOCK_LEN_DEF = 64;
	localparam int COEF_W = 16;
	localparam int POS_W = 6;
	localparam int RUN_W = 4;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic [POS_W-1:0] position;
		logic last;
		logic block_done;
		logic overflow;
	} result_t;

endpackage

>>> rtl/jrle_ctrl.sv
// Token sequencer: position counter, result counter and result formation.
module jrle_ctrl #(
	parameter int BLOCK_LEN = jrle_pkg::BLOCK_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic is_dc,
	input  logic [jrle_pkg::RUN_W-1:0] zero_run,
	input  logic [jrle_pkg::RUN_W-1:0] bit_size,
	input  logic signed [jrle_pkg::COEF_W-1:0] value,
	input  logic slot_free,
	output logic res_valid,
	output jrle_pkg::result_t res
);

	localparam int PW = $clog2(BLOCK_LEN);
	localparam int CW = PW + 1;
	localparam int SW = PW + 5;

	jrle_pkg::state_t state_q, state_d;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_next;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_load;
	logic has_val_q, ovf_q;
	logic signed [jrle_pkg::COEF_W-1:0] val_q;
	logic [SW-1:0] pos_sum, pos_rem;
	logic [PW+5:0] pos_ext;
	logic eob, cut, accept, step, final_res;

	assign accept = in_valid && in_ready;
	assign final_res = (cnt_q == CW'(1));
	assign pos_sum = SW'(pos_q) + SW'(zero_run);
	assign pos_rem = SW'(BLOCK_LEN) - SW'(pos_q);
	assign eob = !is_dc && (zero_run == '0) && (bit_size == '0);
	assign cut = !is_dc && !eob && (pos_sum >= SW'(BLOCK_LEN));
	assign pos_next = (pos_q == PW'(BLOCK_LEN - 1)) ? '0 : pos_q + PW'(1);
	assign pos_ext = (PW + 6)'(pos_q);

	always_comb begin
		if (is_dc) begin
			cnt_load = CW'(1);
		end else if (eob || cut) begin
			cnt_load = CW'(pos_rem);
		end else begin
			cnt_load = CW'(SW'(zero_run) + SW'(1));
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			jrle_pkg::ST_IDLE: begin
				if (in_valid) state_d = jrle_pkg::ST_EMIT;
			end
			jrle_pkg::ST_EMIT: begin
				if (step && final_res) state_d = jrle_pkg::ST_IDLE;
			end
			default: state_d = jrle_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		step = 1'b0;
		case (state_q)
			jrle_pkg::ST_IDLE: in_ready = 1'b1;
			jrle_pkg::ST_EMIT: step = slot_free;
			default: in_ready = 1'b0;
		endcase
	end

	assign res_valid = step;
	assign res.coefficient = (final_res && has_val_q) ? val_q : '0;
	assign res.position = pos_ext[jrle_pkg::POS_W-1:0];
	assign res.last = final_res;
	assign res.block_done = (pos_q == PW'(BLOCK_LEN - 1));
	assign res.overflow = final_res && ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jrle_pkg::ST_IDLE;
			pos_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= cnt_load;
			end else if (step) begin
				cnt_q <= cnt_q - CW'(1);
				pos_q <= pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
			has_val_q <= is_dc || (!eob && !cut);
			ovf_q <= cut;
		end
	end

endmodule

>>> rtl/jrle_out.sv
// Output register stage that holds one result until the receiver takes it.
module jrle_out (
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	input  jrle_pkg::result_t res,
	output logic slot_free,
	output logic out_valid,
	input  logic out_ready,
	output jrle_pkg::result_t out_res
);

	logic valid_q;
	jrle_pkg::result_t res_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) res_q <= res;
	end

endmodule

>>> rtl/jpeg_run_length_expander_core.sv
// Run-length expander: turns coefficient tokens into zigzag-ordered block coefficients.
//
// Input channel (in_valid/in_ready) takes one token: is_dc, zero_run, bit_size and value.
// Output channel (out_valid/out_ready) gives one coefficient per request with its
// position in the block, a last flag on the final result of the token, block_done at
// the final block position and overflow when a token ran past the block end.
// A DC token gives one result, an end-of-block token gives zeros through the end of
// the block, and any other token gives zero_run zeros followed by its value, or only
// zeros to the block end if the value would fall past it. An accepted token producing
// N results occupies the sequencer after the accepting cycle until its last result,
// one result per cycle while the output register has room, set by the single result
// counter that walks the position register; in_ready is high only between tokens. The
// first result is formed once the state register holds the emit state, then passes
// through the output register to the output channel. When the receiver stalls, the
// output register holds its result and the sequencer waits; nothing is lost. Reset
// clears the position to the start of a block and empties the output register.
module jpeg_run_length_expander_core #(
	parameter int BLOCK_LEN = jrle_pkg::BLOCK_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic is_dc,
	input  logic [jrle_pkg::RUN_W-1:0] zero_run,
	input  logic [jrle_pkg::RUN_W-1:0] bit_size,
	input  logic signed [jrle_pkg::COEF_W-1:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [jrle_pkg::COEF_W-1:0] coefficient,
	output logic [jrle_pkg::POS_W-1:0] position,
	output logic last,
	output logic block_done,
	output logic overflow
);

	logic slot_free, res_valid;
	jrle_pkg::result_t res, out_res;

	jrle_ctrl #(
		.BLOCK_LEN(BLOCK_LEN)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.is_dc(is_dc),
		.zero_run(zero_run),
		.bit_size(bit_size),
		.value(value),
		.slot_free(slot_free),
		.res_valid(res_valid),
		.res(res)
	);

	jrle_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res(res),
		.slot_free(slot_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res(out_res)
	);

	assign coefficient = out_res.coefficient;
	assign position = out_res.position;
	assign last = out_res.last;
	assign block_done = out_res.block_done;
	assign overflow = out_res.overflow;

	a_ovf_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> last)
		else $error("overflow flagged on a result that is not the last of its token");

	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_done |-> position == jrle_pkg::POS_W'(BLOCK_LEN - 1))
		else $error("block_done flagged away from the final block position");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new token accepted before the previous token produced a result");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !last |=> !in_ready)
		else $error("sequencer went idle while a non-final result was stalled");

endmodule
